// ===== rtl/tlc_pkg.sv =====
// Shared types and constants of the two-segment LRU byte cache.
// No dependencies; used by every module of the block.
package tlc_pkg;

  localparam int unsigned HEAD_ENTRIES_DEF = 64;
  localparam int unsigned TAIL_ENTRIES_DEF = 64;

  localparam int unsigned TAG_W   = 32;
  localparam int unsigned SIZE_W  = 32;
  localparam int unsigned STAMP_W = 32;
  localparam int unsigned CAP_W   = 41;
  localparam int unsigned SUM_W   = 64;

  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(29360128);

  localparam int unsigned IN_DATA_W  = 96;   // key, size, time
  localparam int unsigned OUT_DATA_W = 136;  // 130 bits used, zero padded

  // configuration register indexes
  localparam logic CFG_HEAD_CAP = 1'b0;
  localparam logic CFG_TAIL_CAP = 1'b1;

  typedef struct packed {
    logic               valid;
    logic [TAG_W-1:0]   tag;
    logic [SIZE_W-1:0]  bytes;
    logic [STAMP_W-1:0] stamp;
  } entry_t;

endpackage

// ===== rtl/tlc_cell.sv =====
// One storage cell of a segment ring: holds a single cache entry.
// Depends on tlc_pkg for the entry type.
module tlc_cell (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            shift_i,
  input  tlc_pkg::entry_t entry_i,
  output tlc_pkg::entry_t entry_o
);

  logic                        valid_q;
  logic [tlc_pkg::TAG_W-1:0]   tag_q;
  logic [tlc_pkg::SIZE_W-1:0]  bytes_q;
  logic [tlc_pkg::STAMP_W-1:0] stamp_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (shift_i) begin
      valid_q <= entry_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      tag_q   <= entry_i.tag;
      bytes_q <= entry_i.bytes;
      stamp_q <= entry_i.stamp;
    end
  end

  assign entry_o = '{valid: valid_q, tag: tag_q, bytes: bytes_q, stamp: stamp_q};

endmodule

// ===== rtl/tlc_ring.sv =====
// One cache segment: a ring of tlc_cell that rotates one place per shift.
// Cell 0 is the inspection point; its possibly modified entry re-enters at the far end.
module tlc_ring #(
  parameter int unsigned ENTRIES = tlc_pkg::HEAD_ENTRIES_DEF
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            shift_i,
  input  tlc_pkg::entry_t wr_entry_i,
  output tlc_pkg::entry_t rd_entry_o
);

  tlc_pkg::entry_t cell_out [ENTRIES];

  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    tlc_pkg::entry_t cell_in;
    if (i == ENTRIES - 1) begin : g_last
      assign cell_in = wr_entry_i;
    end else begin : g_mid
      assign cell_in = cell_out[i+1];
    end
    tlc_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .shift_i (shift_i),
      .entry_i (cell_in),
      .entry_o (cell_out[i])
    );
  end

  assign rd_entry_o = cell_out[0];

endmodule

// ===== rtl/two_segment_lru_byte_cache.sv =====
// Two-segment LRU byte cache. Each segment is a ring of entry cells that rotates past
// one inspection cell, so every lookup, victim search, eviction or insertion is one
// full rotation of that segment. A request is looked up in tail first, then in head.
// A miss runs head scans and head evictions, and per moved victim tail scans/evictions
// plus the tail insertion, and finally the head insertion; an object not smaller than
// the head capacity is not inserted. The result waits in an output register; a new
// request is taken once the block is idle.
module two_segment_lru_byte_cache #(
  parameter int unsigned HEAD_ENTRIES = tlc_pkg::HEAD_ENTRIES_DEF,
  parameter int unsigned TAIL_ENTRIES = tlc_pkg::TAIL_ENTRIES_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // object_key, object_size, request_time (from bit 0 up)
  input  logic [tlc_pkg::IN_DATA_W-1:0]    s_axis_tdata,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // hit, hit_segment, total_bytes, hit_bytes_total, zero pad (from bit 0 up)
  output logic [tlc_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  input  logic                             cfg_we_i,
  input  logic                             cfg_idx_i,
  input  logic [tlc_pkg::CAP_W-1:0]        cfg_data_i
);

  localparam int unsigned MAXN = (HEAD_ENTRIES > TAIL_ENTRIES) ? HEAD_ENTRIES : TAIL_ENTRIES;
  localparam int unsigned CW   = $clog2(MAXN);
  localparam logic [CW-1:0] HLAST = CW'(HEAD_ENTRIES - 1);
  localparam logic [CW-1:0] TLAST = CW'(TAIL_ENTRIES - 1);
  localparam int unsigned CAP_W = tlc_pkg::CAP_W;

  typedef enum logic [3:0] {
    ST_IDLE, ST_TLOOK, ST_HLOOK, ST_HSCAN, ST_HEVICT,
    ST_TSCAN, ST_TEVICT, ST_TINS, ST_HINS, ST_DONE
  } state_e;

  state_e state_q;
  logic [CW-1:0] cnt_q;

  logic [31:0] key_q, size_q, now_q;
  logic        hit_q, seg_q;
  logic [CAP_W-1:0] head_cap_q, tail_cap_q, head_used_q, tail_used_q;
  logic [63:0] req_sum_q, hit_sum_q;

  // per-rotation accumulators
  logic        found_q, free_q, vv_q, ins_done_q;
  logic [31:0] vtag_q, vbytes_q, vstamp_q;
  // latched head victim and tail victim
  logic [31:0] hv_tag_q, hv_bytes_q, hv_stamp_q, tv_tag_q;

  logic [CAP_W-1:0] head_used_d, tail_used_d;

  tlc_pkg::entry_t h_rd, t_rd, e, mod;
  logic on_tail, in_pass, last, match, better;
  logic found_n, free_n, vv_n;
  logic [31:0] vtag_n, vbytes_n, vstamp_n;
  logic h_fits, t_fits, t_small;
  logic [CAP_W:0] h_sum, t_sum;

  assign on_tail = (state_q == ST_TLOOK) || (state_q == ST_TSCAN) ||
                   (state_q == ST_TEVICT) || (state_q == ST_TINS);
  assign in_pass = (state_q != ST_IDLE) && (state_q != ST_DONE);
  assign last    = on_tail ? (cnt_q == TLAST) : (cnt_q == HLAST);
  assign e       = on_tail ? t_rd : h_rd;
  assign match   = e.valid && (e.tag == key_q);

  assign better = e.valid && (!vv_q || (e.stamp < vstamp_q) ||
                  ((e.stamp == vstamp_q) && ((e.bytes > vbytes_q) ||
                   ((e.bytes == vbytes_q) && (e.tag < vtag_q)))));
  assign found_n  = found_q | match;
  assign free_n   = free_q | !e.valid;
  assign vv_n     = vv_q | e.valid;
  assign vtag_n   = better ? e.tag   : vtag_q;
  assign vbytes_n = better ? e.bytes : vbytes_q;
  assign vstamp_n = better ? e.stamp : vstamp_q;

  assign h_sum   = {1'b0, head_used_q} + (CAP_W+1)'(size_q);
  assign t_sum   = {1'b0, tail_used_q} + (CAP_W+1)'(hv_bytes_q);
  assign h_fits  = free_n && (h_sum <= {1'b0, head_cap_q});
  assign t_fits  = free_n && (t_sum <= {1'b0, tail_cap_q});
  assign t_small = CAP_W'(hv_bytes_q) < tail_cap_q;

  always_comb begin
    mod = e;
    unique case (state_q)
      ST_TLOOK, ST_HLOOK: if (match) mod.stamp = now_q;
      ST_HEVICT: if (e.valid && e.tag == hv_tag_q) mod.valid = 1'b0;
      ST_TEVICT: if (e.valid && e.tag == tv_tag_q) mod.valid = 1'b0;
      ST_TINS: if (!e.valid && !ins_done_q)
        mod = '{valid: 1'b1, tag: hv_tag_q, bytes: hv_bytes_q, stamp: hv_stamp_q};
      ST_HINS: if (!e.valid && !ins_done_q)
        mod = '{valid: 1'b1, tag: key_q, bytes: size_q, stamp: now_q};
      default: mod = e;
    endcase
  end

  tlc_ring #(.ENTRIES(HEAD_ENTRIES)) u_head (
    .clk_i (clk_i), .rst_ni (rst_ni), .shift_i (in_pass && !on_tail),
    .wr_entry_i (mod), .rd_entry_o (h_rd)
  );
  tlc_ring #(.ENTRIES(TAIL_ENTRIES)) u_tail (
    .clk_i (clk_i), .rst_ni (rst_ni), .shift_i (in_pass && on_tail),
    .wr_entry_i (mod), .rd_entry_o (t_rd)
  );

  always_comb begin
    head_used_d = head_used_q;
    tail_used_d = tail_used_q;
    if (last) begin
      priority case (state_q)
        ST_HSCAN: if (!h_fits && vv_n) head_used_d = head_used_q - CAP_W'(vbytes_n);
        ST_TSCAN: if (!t_fits && vv_n) tail_used_d = tail_used_q - CAP_W'(vbytes_n);
        ST_TINS:  tail_used_d = tail_used_q + CAP_W'(hv_bytes_q);
        ST_HINS:  head_used_d = head_used_q + CAP_W'(size_q);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_cap_q <= tlc_pkg::CAP_RESET;
      tail_cap_q <= tlc_pkg::CAP_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        tlc_pkg::CFG_HEAD_CAP: head_cap_q <= cfg_data_i;
        tlc_pkg::CFG_TAIL_CAP: tail_cap_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      key_q  <= s_axis_tdata[31:0];
      size_q <= s_axis_tdata[63:32];
      now_q  <= s_axis_tdata[95:64];
    end
    if (last && in_pass) begin
      if (state_q == ST_HSCAN) begin
        hv_tag_q   <= vtag_n;
        hv_bytes_q <= vbytes_n;
        hv_stamp_q <= vstamp_n;
      end
      if (state_q == ST_TSCAN) tv_tag_q <= vtag_n;
    end
    if (in_pass) begin
      vtag_q   <= vtag_n;
      vbytes_q <= vbytes_n;
      vstamp_q <= vstamp_n;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      cnt_q         <= '0;
      hit_q         <= 1'b0;
      seg_q         <= 1'b0;
      found_q       <= 1'b0;
      free_q        <= 1'b0;
      vv_q          <= 1'b0;
      ins_done_q    <= 1'b0;
      head_used_q   <= '0;
      tail_used_q   <= '0;
      req_sum_q     <= '0;
      hit_sum_q     <= '0;
      m_axis_tvalid <= 1'b0;
      m_axis_tdata  <= '0;
    end else begin
      head_used_q <= head_used_d;
      tail_used_q <= tail_used_d;
      // in ST_DONE the result register is reloaded below instead
      if (m_axis_tvalid && m_axis_tready && (state_q != ST_DONE)) m_axis_tvalid <= 1'b0;
      if (in_pass) begin
        cnt_q      <= last ? '0 : cnt_q + 1'b1;
        found_q    <= last ? 1'b0 : found_n;
        free_q     <= last ? 1'b0 : free_n;
        vv_q       <= last ? 1'b0 : vv_n;
        ins_done_q <= last ? 1'b0 : (ins_done_q | !e.valid);
      end
      unique case (state_q)
        ST_IDLE: if (s_axis_tvalid) begin
          req_sum_q <= req_sum_q + 64'(s_axis_tdata[63:32]);
          hit_q     <= 1'b0;
          seg_q     <= 1'b0;
          state_q   <= ST_TLOOK;
        end
        ST_TLOOK: if (last) begin
          if (found_n) begin
            hit_q   <= 1'b1;
            seg_q   <= 1'b1;
            state_q <= ST_DONE;
          end else begin
            state_q <= ST_HLOOK;
          end
        end
        ST_HLOOK: if (last) begin
          if (found_n) begin
            hit_q   <= 1'b1;
            state_q <= ST_DONE;
          end else if (CAP_W'(size_q) < head_cap_q) begin
            state_q <= ST_HSCAN;
          end else begin
            state_q <= ST_DONE;
          end
        end
        ST_HSCAN: if (last) state_q <= (h_fits || !vv_n) ? ST_HINS : ST_HEVICT;
        ST_HEVICT: if (last) state_q <= t_small ? ST_TSCAN : ST_HSCAN;
        ST_TSCAN: if (last) state_q <= (t_fits || !vv_n) ? ST_TINS : ST_TEVICT;
        ST_TEVICT: if (last) state_q <= ST_TSCAN;
        ST_TINS: if (last) state_q <= ST_HSCAN;
        ST_HINS: if (last) state_q <= ST_DONE;
        ST_DONE: if (!m_axis_tvalid || m_axis_tready) begin
          m_axis_tvalid <= 1'b1;
          m_axis_tdata  <= {6'b0, hit_q ? hit_sum_q + 64'(size_q) : hit_sum_q,
                            req_sum_q, seg_q, hit_q};
          if (hit_q) hit_sum_q <= hit_sum_q + 64'(size_q);
          state_q <= ST_IDLE;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign s_axis_tready = (state_q == ST_IDLE);

endmodule

// ===== rtl/tlc_checker.sv =====
// Port-level checks for two_segment_lru_byte_cache, attached by bind.
// Depends on tlc_pkg for widths.
module tlc_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           s_axis_tvalid,
  input logic                           s_axis_tready,
  input logic [tlc_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  input logic                           m_axis_tvalid,
  input logic                           m_axis_tready
);

  // held result stays put
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // one request at a time
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("request taken while busy");

  // a miss never reports the tail segment
  a_miss_seg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tdata[0] |-> !m_axis_tdata[1])
    else $error("miss with tail segment set");

  // padding bits are zero
  a_pad: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[135:130] == 6'b0)
    else $error("nonzero padding");

endmodule

bind two_segment_lru_byte_cache tlc_checker u_tlc_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready)
);
